@@ design/r2fft_pkg.sv @@
// Package with the constants, types and ROM functions of the radix-2 frame FFT engine.
`timescale 1ns / 1ps
package r2fft_pkg;

    localparam int POINTS = 64;
    localparam int STAGES = $clog2(POINTS);
    localparam int AW = (STAGES < 1) ? 1 : STAGES;
    localparam int CW = STAGES + 1;
    localparam int F24_MAX = 8388607;
    localparam int F24_MIN = -8388608;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SWAP_RD,
        ST_SWAP_WAIT,
        ST_SWAP_WR,
        ST_BF_RD,
        ST_BF_WAIT,
        ST_BF_MUL,
        ST_BF_WR,
        ST_OUT_RD,
        ST_OUT_WAIT
    } state_t;

    function automatic logic signed [18:0] cos_rom(input logic [5:0] k);
        logic [4:0] q;
        logic signed [18:0] v;
        logic [17:0] tab [0:16];
        tab = '{18'd131071, 18'd130441, 18'd128553, 18'd125428, 18'd121095,
                18'd115595, 18'd108982, 18'd101320, 18'd92682, 18'd83151,
                18'd72820, 18'd61787, 18'd50159, 18'd38048, 18'd25571,
                18'd12847, 18'd0};
        q = 5'd0;
        v = 19'sd0;
        if (k <= 6'd16) begin
            q = k[4:0];
            v = $signed({1'b0, tab[q]});
        end else if (k <= 6'd32) begin
            q = 5'(6'd32 - k);
            v = -$signed({1'b0, tab[q]});
        end else if (k <= 6'd48) begin
            q = 5'(k - 6'd32);
            v = -$signed({1'b0, tab[q]});
        end else begin
            q = 5'(7'd64 - {1'b0, k});
            v = $signed({1'b0, tab[q]});
        end
        return v;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'sd8388607) r = 24'sh7FFFFF;
        else if (v < -48'sd8388608) r = 24'sh800000;
        else r = v[23:0];
        return r;
    endfunction

    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] i);
        logic [AW-1:0] r;
        for (int b = 0; b < AW; b++) r[b] = i[AW-1-b];
        return r;
    endfunction

endpackage

@@ design/radix2_fft_frame_engine_unit.sv @@
// Top level of the radix-2 frame FFT engine with Hann window.
`timescale 1ns / 1ps
// The block takes one frame of POINTS complex samples as items on the command
// port: an item is accepted at a rising edge where start is high and busy is
// low. func is read on the first item of each frame: 0 selects the windowed
// forward transform, 1 the inverse transform. Each forward load item passes
// its Hann product through the multiplier before it is written, and busy stays
// high while it is written; an inverse item is written as it is accepted.
// After the last item of a frame the block stays busy while it reorders the
// store in bit-reversed order (every index is checked and each swapped pair is
// read and written back) and then runs (POINTS/2)*log2(POINTS) butterflies
// through one butterfly unit, each read, multiplied and written back, reading
// and writing the single frame store RAM.
// It then delivers POINTS results in bin order, each read from the store and
// marked by valid for one cycle; last marks the final one. The receiver
// cannot stall: every result is taken the cycle it is shown.
// Reset clears the sequencer, the load count and the mode; the store needs
// no clearing because every entry is written before it is read.
module radix2_fft_frame_engine_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [23:0] in_re,
    input  logic signed [23:0] in_im,
    output logic               valid,
    output logic signed [23:0] out_re,
    output logic signed [23:0] out_im,
    output logic               last
);

    localparam int AW = r2fft_pkg::AW;
    localparam int CW = r2fft_pkg::CW;
    localparam int ST = r2fft_pkg::STAGES;

    r2fft_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [3:0]    stg_reg, stg_next;
    logic          mode_reg, mode_next;
    logic          phase_reg, phase_next;
    logic signed [23:0] ld_re_reg, ld_re_next;
    logic signed [18:0] ld_w_reg, ld_w_next;
    logic signed [23:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [23:0] ar_next, ai_next, br_next, bi_next;
    logic signed [23:0] tr_reg, ti_reg, tr_next, ti_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [47:0]   wdata, rdata;

    r2fft_ram #(.WIDTH(48), .DEPTH(1 << AW)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Butterfly indexing.
    logic [AW-1:0] bj, half, ia, ib, tw_idx, idx_cnt, rev;
    logic [5:0]    twk;
    logic signed [18:0] wr, wi;
    logic signed [47:0] sum_a, sum_b;
    logic signed [42:0] mul_a, mul_b;
    logic signed [24:0] neg_im;
    logic signed [24:0] scaled;

    always_comb
    begin
        idx_cnt = cnt_reg[AW-1:0];
        rev     = r2fft_pkg::bit_rev(idx_cnt);
        half    = AW'(1 << (stg_reg - 4'd1));
        bj      = idx_cnt & (half - AW'(1));
        ia      = ((idx_cnt & ~(half - AW'(1))) << 1) | bj;
        ib      = ia | half;
        tw_idx  = AW'(bj << (ST - stg_reg));
        twk     = 6'(tw_idx) << (6 - ST);
        wr      = r2fft_pkg::cos_rom(twk);
        wi      = -r2fft_pkg::cos_rom(6'(twk + 6'd48));
    end

    // The Hann product shares mul_a with the real part of the twiddle product, which uses both multipliers.
    always_comb
    begin
        mul_a = 43'sd0;
        mul_b = 43'sd0;
        if (state_reg == r2fft_pkg::ST_LOAD)
        begin
            mul_a = ld_re_reg * ld_w_reg;
        end else begin
            mul_a = wr * br_reg;
            mul_b = wi * bi_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= r2fft_pkg::ST_LOAD;
            cnt_reg   <= '0;
            stg_reg   <= '0;
            mode_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stg_reg   <= stg_next;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_re_reg <= ld_re_next;
        ld_w_reg  <= ld_w_next;
        ar_reg <= ar_next;
        ai_reg <= ai_next;
        br_reg <= br_next;
        bi_reg <= bi_next;
        tr_reg <= tr_next;
        ti_reg <= ti_next;
    end

    logic signed [23:0] pre_r, pre_i;
    logic signed [47:0] mp_reg, mp_next;
    logic [AW-1:0] ld_pos;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        stg_next   = stg_reg;
        mode_next  = mode_reg;
        phase_next = phase_reg;
        ld_re_next = ld_re_reg;
        ld_w_next  = ld_w_reg;
        ar_next = ar_reg; ai_next = ai_reg;
        br_next = br_reg; bi_next = bi_reg;
        tr_next = tr_reg; ti_next = ti_reg;
        mp_next = mp_reg;
        we    = 1'b0;
        waddr = idx_cnt;
        wdata = '0;
        raddr = idx_cnt;
        busy  = 1'b1;
        valid = 1'b0;
        out_re = '0;
        out_im = '0;
        last   = 1'b0;
        sum_a = '0; sum_b = '0;
        neg_im = -{in_im[23], in_im};
        scaled = '0;
        pre_r = rdata[47:24];
        pre_i = rdata[23:0];
        ld_pos = idx_cnt;
        unique case (state_reg)
            r2fft_pkg::ST_LOAD:
            begin
                if (!phase_reg)
                begin
                    busy = 1'b0;
                    if (start)
                    begin
                        if (cnt_reg == '0)
                        begin
                            mode_next = func;
                        end
                        if ((cnt_reg == '0) ? func : mode_reg)
                        begin
                            we = 1'b1;
                            wdata = {in_re, r2fft_pkg::sat24(48'(neg_im))};
                            cnt_next = cnt_reg + CW'(1);
                        end else begin
                            ld_re_next = in_re;
                            ld_w_next = 19'((19'sd131072 - r2fft_pkg::cos_rom(
                                6'(ld_pos) << (6 - ST))) >>> 1);
                            if (ld_w_next > 19'sd131071) ld_w_next = 19'sd131071;
                            phase_next = 1'b1;
                        end
                    end
                end else begin
                    we = 1'b1;
                    wdata = {r2fft_pkg::sat24(48'((mul_a + 43'sd65536) >>> 17)), 24'sd0};
                    cnt_next = cnt_reg + CW'(1);
                    phase_next = 1'b0;
                end
                if (cnt_next == CW'(1 << ST) && we)
                begin
                    cnt_next = '0;
                    state_next = r2fft_pkg::ST_SWAP_RD;
                end
            end
            r2fft_pkg::ST_SWAP_RD:
            begin
                if (idx_cnt < rev)
                begin
                    raddr = idx_cnt;
                    state_next = r2fft_pkg::ST_SWAP_WAIT;
                end else if (cnt_reg == CW'((1 << ST) - 1))
                begin
                    cnt_next = '0;
                    stg_next = 4'd1;
                    state_next = r2fft_pkg::ST_BF_RD;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            r2fft_pkg::ST_SWAP_WAIT:
            begin
                raddr = rev;
                ar_next = pre_r;
                ai_next = pre_i;
                state_next = r2fft_pkg::ST_SWAP_WR;
            end
            r2fft_pkg::ST_SWAP_WR:
            begin
                if (!phase_reg)
                begin
                    we = 1'b1;
                    waddr = idx_cnt;
                    wdata = rdata;
                    phase_next = 1'b1;
                end else begin
                    we = 1'b1;
                    waddr = rev;
                    wdata = {ar_reg, ai_reg};
                    phase_next = 1'b0;
                    cnt_next = cnt_reg + CW'(1);
                    state_next = r2fft_pkg::ST_SWAP_RD;
                end
            end
            r2fft_pkg::ST_BF_RD:
            begin
                raddr = ia;
                state_next = r2fft_pkg::ST_BF_WAIT;
            end
            r2fft_pkg::ST_BF_WAIT:
            begin
                raddr = ib;
                ar_next = pre_r;
                ai_next = pre_i;
                state_next = r2fft_pkg::ST_BF_MUL;
                phase_next = 1'b0;
            end
            r2fft_pkg::ST_BF_MUL:
            begin
                if (!phase_reg)
                begin
                    br_next = pre_r;
                    bi_next = pre_i;
                    phase_next = 1'b1;
                end else begin
                    // Real part of the twiddle product.
                    mp_next = 48'(mul_a) - 48'(mul_b);
                    sum_a = 48'(wr * bi_reg);
                    sum_b = 48'(wi * br_reg);
                    ti_next = r2fft_pkg::sat24((sum_a + sum_b + 48'sd65536) >>> 17);
                    tr_next = r2fft_pkg::sat24((mp_next + 48'sd65536) >>> 17);
                    phase_next = 1'b0;
                    state_next = r2fft_pkg::ST_BF_WR;
                end
            end
            r2fft_pkg::ST_BF_WR:
            begin
                we = 1'b1;
                if (!phase_reg)
                begin
                    waddr = ia;
                    wdata = {r2fft_pkg::sat24(48'(ar_reg) + 48'(tr_reg)),
                             r2fft_pkg::sat24(48'(ai_reg) + 48'(ti_reg))};
                    phase_next = 1'b1;
                end else begin
                    waddr = ib;
                    wdata = {r2fft_pkg::sat24(48'(ar_reg) - 48'(tr_reg)),
                             r2fft_pkg::sat24(48'(ai_reg) - 48'(ti_reg))};
                    phase_next = 1'b0;
                    state_next = r2fft_pkg::ST_BF_RD;
                    if (cnt_reg == CW'((1 << (ST - 1)) - 1))
                    begin
                        cnt_next = '0;
                        if (stg_reg == 4'(ST))
                        begin
                            state_next = r2fft_pkg::ST_OUT_RD;
                        end else begin
                            stg_next = stg_reg + 4'd1;
                        end
                    end else begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            r2fft_pkg::ST_OUT_RD:
            begin
                raddr = idx_cnt;
                state_next = r2fft_pkg::ST_OUT_WAIT;
            end
            r2fft_pkg::ST_OUT_WAIT:
            begin
                valid = 1'b1;
                last = (cnt_reg == CW'((1 << ST) - 1));
                if (mode_reg)
                begin
                    scaled = 25'((25'(pre_r) + 25'(1 << (ST - 1))) >>> ST);
                    out_re = r2fft_pkg::sat24(48'(scaled));
                    out_im = '0;
                end else begin
                    out_re = pre_r;
                    out_im = pre_i;
                end
                if (last)
                begin
                    cnt_next = '0;
                    state_next = r2fft_pkg::ST_LOAD;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                    state_next = r2fft_pkg::ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = r2fft_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mp_reg <= mp_next;
    end

`ifndef ASSERT_OFF
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("result shown while idle");
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> (state_reg == r2fft_pkg::ST_LOAD && cnt_reg == '0))
        else $error("frame did not return to load after last");
    a_inv_im: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && mode_reg) |-> (out_im == 24'sd0)) else $error("inverse imag nonzero");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(1 << ST)) else $error("count out of range");
`endif

endmodule

@@ design/r2fft_ram.sv @@
// Generic single-port-write, one-port-read RAM with a registered read.
`timescale 1ns / 1ps
module r2fft_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
